/* rtl/multi_mode_byte_frame_assembler_unit_assert.svh */
`ifndef MULTI_MODE_BYTE_FRAME_ASSEMBLER_UNIT_ASSERT_SVH
`define MULTI_MODE_BYTE_FRAME_ASSEMBLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MMBFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMBFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mmbfa_pkg.sv */
package mmbfa_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_RESYNC = 2'd2;

   // Framing modes.
   localparam logic [1:0] MODE_DELIM    = 2'd0;
   localparam logic [1:0] MODE_FIXED    = 2'd1;
   localparam logic [1:0] MODE_SENTINEL = 2'd2;
   localparam logic [1:0] MODE_IDLE     = 2'd3;

   // Register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER_BYTES  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_LENGTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH       = 3'd7;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  frame_byte;
      logic        last_of_frame;
      logic [31:0] frames_total;
      logic [31:0] drops_total;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  frame_mode;
      logic [31:0] delimiter_bytes;
      logic [2:0]  delimiter_length;
      logic [6:0]  fixed_length;
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [15:0] idle_timeout;
      logic [6:0]  max_length;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_mode:       MODE_DELIM,
      delimiter_bytes:  32'd10,
      delimiter_length: 3'd1,
      fixed_length:     7'd64,
      start_byte:       8'd2,
      end_byte:         8'd3,
      idle_timeout:     16'd100,
      max_length:       7'd0
   };

endpackage

/* rtl/mmbfa_delim_window.sv */
module mmbfa_delim_window #(
   parameter int DELIM_MAX = 4
) (
   input  logic                             clock,
   input  logic                             shift_en,
   input  logic [7:0]                       shift_byte,
   input  logic [31:0]                      delim_bytes,
   input  logic [$clog2(DELIM_MAX + 1)-1:0] delim_len,
   output logic                             tail_match
);
   import mmbfa_pkg::*;

   // Entry 0 holds the most recently stored byte.
   logic [DELIM_MAX-1:0][7:0] win_ff;
   logic [DELIM_MAX-1:0][7:0] win_in;

   always_comb begin
      win_in = win_ff;
      if (shift_en) begin
         win_in[0] = shift_byte;
         for (int j = 1; j < DELIM_MAX; j++) begin
            win_in[j] = win_ff[j-1];
         end
      end
   end

   // Compare against the window as it stands after this byte. Only the first
   // four delimiter bytes exist, so a longer delimiter never matches.
   always_comb begin
      int k;
      k = 0;
      tail_match = (int'(delim_len) <= 4);
      for (int j = 0; j < DELIM_MAX; j++) begin
         if (j < int'(delim_len)) begin
            k = int'(delim_len) - 1 - j;
            if (win_in[j] != delim_bytes[8*k[1:0] +: 8]) begin
               tail_match = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff <= win_in;
      end
   end

endmodule

/* rtl/multi_mode_byte_frame_assembler_unit.sv */
// A request is taken in ST_IDLE and its results come in ST_EMIT: a status result goes straight
// to the output register, payload bytes go through the read stage s1, one byte per cycle while
// the output does not stall. No new request is taken until the last result has left s1.
// Reset (synchronous, active high) restores register defaults, clears framing state and
// counters; the frame memory keeps its contents and needs no clearing pass.
`include "multi_mode_byte_frame_assembler_unit_assert.svh"

module multi_mode_byte_frame_assembler_unit #(
   parameter int FRAME_MAX = 64,
   parameter int DELIM_MAX = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mmbfa_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mmbfa_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mmbfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata
);
   import mmbfa_pkg::*;

   localparam int FILL_W   = $clog2(FRAME_MAX + 1);
   localparam int ADDR_W   = $clog2(FRAME_MAX);
   localparam int SUM_W    = FILL_W + 1;
   localparam int DL_W     = $clog2(DELIM_MAX + 1);
   localparam int DLEN_CAP = (DELIM_MAX < FRAME_MAX) ? DELIM_MAX : FRAME_MAX;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } seq_state_type;

   // The frame memory is used as a ring. A frame starts at base_ff, so the
   // sliding window of discard mode only moves the base instead of copying
   // the kept delimiter bytes to the front.
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                  input logic [FILL_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      if (s >= SUM_W'(FRAME_MAX)) begin
         s = s - SUM_W'(FRAME_MAX);
      end
      return s[ADDR_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken.
   // ---------------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_MODE:       cfg_in.frame_mode       = csr_wdata[1:0];
            CSR_DELIMITER_BYTES:  cfg_in.delimiter_bytes  = csr_wdata;
            CSR_DELIMITER_LENGTH: cfg_in.delimiter_length = csr_wdata[2:0];
            CSR_FIXED_LENGTH:     cfg_in.fixed_length     = csr_wdata[6:0];
            CSR_START_BYTE:       cfg_in.start_byte       = csr_wdata[7:0];
            CSR_END_BYTE:         cfg_in.end_byte         = csr_wdata[7:0];
            CSR_IDLE_TIMEOUT:     cfg_in.idle_timeout     = csr_wdata[15:0];
            CSR_MAX_LENGTH:       cfg_in.max_length       = csr_wdata[6:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // Effective limits. A zero or oversized maximum means the full buffer,
   // the delimiter length is clamped to 1..min(DELIM_MAX, FRAME_MAX), and the
   // fixed length to 1..maximum.
   logic [FILL_W-1:0] max_eff;
   logic [6:0]        fixed_raw;
   logic [FILL_W-1:0] fixed_eff;
   logic [2:0]        dlen_raw;
   logic [DL_W-1:0]   dlen_eff;
   logic [FILL_W-1:0] dlen_fill;

   always_comb begin
      if (cfg_ff.max_length == 7'd0 || cfg_ff.max_length > FRAME_MAX) begin
         max_eff = FILL_W'(FRAME_MAX);
      end else begin
         max_eff = FILL_W'(cfg_ff.max_length);
      end
      fixed_raw = (cfg_ff.fixed_length == 7'd0) ? 7'd1 : cfg_ff.fixed_length;
      fixed_eff = (fixed_raw > max_eff) ? max_eff : FILL_W'(fixed_raw);
      dlen_raw  = (cfg_ff.delimiter_length == 3'd0) ? 3'd1 : cfg_ff.delimiter_length;
      dlen_eff  = (dlen_raw > DLEN_CAP) ? DL_W'(DLEN_CAP) : DL_W'(dlen_raw);
      dlen_fill = FILL_W'(dlen_eff);
   end

   // ---------------------------------------------------------------------
   // Framing state, updated only when a request is accepted.
   // ---------------------------------------------------------------------
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              disc_ff, disc_in;
   logic              inside_ff, inside_in;
   logic [15:0]       quiet_ff, quiet_in;
   logic              seen_ff, seen_in;
   logic [31:0]       frame_cnt_ff, frame_cnt_in;
   logic [31:0]       drop_cnt_ff, drop_cnt_in;

   seq_state_type     state_ff, state_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              req_accept;

   assign req_ready  = (state_ff == ST_IDLE) && !s1_valid_ff;
   assign req_accept = req_valid && req_ready;

   // Byte path decisions that do not depend on the delimiter compare.
   logic              is_data;
   logic              disc_move;
   logic [FILL_W-1:0] fill_base;
   logic [ADDR_W-1:0] base_mv;
   logic              store_path;
   logic              do_store;
   logic [FILL_W-1:0] fill_after;
   logic [ADDR_W-1:0] wr_addr;
   logic              mem_we;
   logic              tail_match;
   logic              tail_hit;

   always_comb begin
      is_data = (req_data.kind == KIND_DATA);
      // While discarding, only the last dlen-1 bytes are kept: slide the base.
      disc_move = (cfg_ff.frame_mode == MODE_DELIM) && disc_ff && (fill_ff >= dlen_fill);
      if (disc_move) begin
         fill_base = dlen_fill - FILL_W'(1);
         base_mv   = ring_add(base_ff, fill_ff - fill_base);
      end else begin
         fill_base = fill_ff;
         base_mv   = base_ff;
      end
      // In sentinel mode only bytes inside a frame that are neither sentinel
      // are stored; the other modes store every byte.
      if (cfg_ff.frame_mode == MODE_SENTINEL) begin
         store_path = inside_ff && (req_data.data_byte != cfg_ff.end_byte)
                      && (req_data.data_byte != cfg_ff.start_byte);
      end else begin
         store_path = 1'b1;
      end
      // A full buffer silently skips the byte.
      do_store   = is_data && store_path && (fill_base != FILL_W'(FRAME_MAX));
      fill_after = do_store ? (fill_base + FILL_W'(1)) : fill_base;
      wr_addr    = ring_add(base_mv, fill_base);
      mem_we     = req_accept && do_store;
   end

   mmbfa_delim_window #(
      .DELIM_MAX (DELIM_MAX)
   ) u_window (
      .clock       (clock),
      .shift_en    (mem_we),
      .shift_byte  (req_data.data_byte),
      .delim_bytes (cfg_ff.delimiter_bytes),
      .delim_len   (dlen_eff),
      .tail_match  (tail_match)
   );

   assign tail_hit = tail_match && (fill_after >= dlen_fill);

   // Next framing state and number of payload bytes to emit.
   logic [FILL_W-1:0] emit_n;
   logic [15:0]       quiet_inc;

   always_comb begin
      fill_in      = fill_ff;
      base_in      = base_ff;
      disc_in      = disc_ff;
      inside_in    = inside_ff;
      quiet_in     = quiet_ff;
      seen_in      = seen_ff;
      frame_cnt_in = frame_cnt_ff;
      drop_cnt_in  = drop_cnt_ff;
      emit_n       = '0;
      quiet_inc    = (quiet_ff != 16'hFFFF) ? (quiet_ff + 16'd1) : quiet_ff;
      case (req_data.kind)
         KIND_DATA: begin
            quiet_in = '0;
            seen_in  = 1'b1;
            case (cfg_ff.frame_mode)
               MODE_DELIM: begin
                  base_in = base_mv;
                  if (disc_ff) begin
                     if (tail_hit) begin
                        disc_in = 1'b0;
                        fill_in = '0;
                     end else begin
                        fill_in = fill_after;
                     end
                  end else if (tail_hit) begin
                     // Empty frames between delimiters are skipped.
                     emit_n = fill_after - dlen_fill;
                     if (emit_n != '0) begin
                        frame_cnt_in = frame_cnt_ff + 32'd1;
                     end
                     fill_in = '0;
                  end else if (fill_after >= max_eff) begin
                     drop_cnt_in = drop_cnt_ff + 32'd1;
                     fill_in     = '0;
                     disc_in     = 1'b1;
                  end else begin
                     fill_in = fill_after;
                  end
               end
               MODE_FIXED: begin
                  if (fill_after >= fixed_eff) begin
                     emit_n       = fill_after;
                     frame_cnt_in = frame_cnt_ff + 32'd1;
                     fill_in      = '0;
                  end else begin
                     fill_in = fill_after;
                  end
               end
               MODE_SENTINEL: begin
                  if (!inside_ff) begin
                     if (req_data.data_byte == cfg_ff.start_byte) begin
                        inside_in = 1'b1;
                        fill_in   = '0;
                     end
                  end else if (req_data.data_byte == cfg_ff.end_byte) begin
                     // The end test comes first, so equal sentinels close a frame.
                     emit_n = fill_ff;
                     if (fill_ff != '0) begin
                        frame_cnt_in = frame_cnt_ff + 32'd1;
                     end
                     inside_in = 1'b0;
                     fill_in   = '0;
                  end else if (req_data.data_byte == cfg_ff.start_byte) begin
                     // A repeated start drops the partial frame and starts over.
                     drop_cnt_in = drop_cnt_ff + 32'd1;
                     fill_in     = '0;
                  end else if (fill_after >= max_eff) begin
                     drop_cnt_in = drop_cnt_ff + 32'd1;
                     fill_in     = '0;
                     inside_in   = 1'b0;
                  end else begin
                     fill_in = fill_after;
                  end
               end
               MODE_IDLE: begin
                  if (fill_after >= max_eff) begin
                     drop_cnt_in = drop_cnt_ff + 32'd1;
                     fill_in     = '0;
                  end else begin
                     fill_in = fill_after;
                  end
               end
               default: begin
                  fill_in = fill_ff;
               end
            endcase
         end
         KIND_TICK: begin
            // Quiet time only counts once a byte has been seen.
            if (seen_ff) begin
               quiet_in = quiet_inc;
               if ((cfg_ff.frame_mode == MODE_IDLE) && (fill_ff != '0)
                   && (quiet_inc >= cfg_ff.idle_timeout)) begin
                  emit_n       = fill_ff;
                  frame_cnt_in = frame_cnt_ff + 32'd1;
                  fill_in      = '0;
               end
            end
         end
         KIND_RESYNC: begin
            fill_in   = '0;
            disc_in   = 1'b0;
            inside_in = 1'b0;
            seen_in   = 1'b0;
            quiet_in  = '0;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Result sequencer. A frame is read out of the memory one byte per cycle
   // into a read stage (s1) and then into the output register; a read is
   // issued only when s1 is empty or moves on in the same cycle.
   // ---------------------------------------------------------------------
   logic [FILL_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;
   logic              rd_last;
   logic [7:0]        rd_data_ff;
   logic              s1_last_ff, s1_last_in;
   logic              status_load;
   logic              out_en;
   logic              s1_free;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   assign out_en  = !rsp_valid_ff || rsp_ready;
   assign s1_free = !s1_valid_ff || out_en;
   assign rd_addr = ring_add(base_ff, FILL_W'(rd_ptr_ff));
   assign rd_last = (FILL_W'(rd_ptr_ff) + FILL_W'(1)) == emit_cnt_ff;

   always_comb begin
      state_in    = state_ff;
      emit_cnt_in = emit_cnt_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_en       = 1'b0;
      status_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in    = ST_EMIT;
               emit_cnt_in = emit_n;
               rd_ptr_in   = '0;
            end
         end
         ST_EMIT: begin
            if (emit_cnt_ff == '0) begin
               // No frame completed: one status result.
               if (out_en) begin
                  status_load = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (s1_free) begin
               rd_en     = 1'b1;
               rd_ptr_in = rd_ptr_ff + ADDR_W'(1);
               if (rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      s1_valid_in  = rd_en || (s1_valid_ff && !out_en);
      s1_last_in   = rd_en ? rd_last : s1_last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      // Counters are stable while a frame drains, since no request is taken.
      if (s1_valid_ff && out_en) begin
         rsp_valid_in         = 1'b1;
         rsp_in.has_byte      = 1'b1;
         rsp_in.frame_byte    = rd_data_ff;
         rsp_in.last_of_frame = s1_last_ff;
         rsp_in.frames_total  = frame_cnt_ff;
         rsp_in.drops_total   = drop_cnt_ff;
      end else if (status_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.has_byte      = 1'b0;
         rsp_in.frame_byte    = '0;
         rsp_in.last_of_frame = 1'b1;
         rsp_in.frames_total  = frame_cnt_ff;
         rsp_in.drops_total   = drop_cnt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Frame memory: one write port at request time, one read port while
   // emitting; the two never act in the same cycle.
   logic [7:0] frame_mem [FRAME_MAX];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_addr] <= req_data.data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      s1_last_ff <= s1_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         fill_ff      <= '0;
         base_ff      <= '0;
         disc_ff      <= 1'b0;
         inside_ff    <= 1'b0;
         quiet_ff     <= '0;
         seen_ff      <= 1'b0;
         frame_cnt_ff <= '0;
         drop_cnt_ff  <= '0;
         state_ff     <= ST_IDLE;
         emit_cnt_ff  <= '0;
         rd_ptr_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         if (req_accept) begin
            fill_ff      <= fill_in;
            base_ff      <= base_in;
            disc_ff      <= disc_in;
            inside_ff    <= inside_in;
            quiet_ff     <= quiet_in;
            seen_ff      <= seen_in;
            frame_cnt_ff <= frame_cnt_in;
            drop_cnt_ff  <= drop_cnt_in;
         end
         state_ff     <= state_in;
         emit_cnt_ff  <= emit_cnt_in;
         rd_ptr_ff    <= rd_ptr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `MMBFA_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(FRAME_MAX), "fill count beyond buffer depth")
   `MMBFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_ready, "request taken while results of the last one are pending")
   `MMBFA_ASSERT_NOW(a_status_is_last, clock, reset, rsp_valid_ff && !rsp_ff.has_byte, rsp_ff.last_of_frame, "status result without last mark")
   `MMBFA_ASSERT_NEXT(a_counts_hold, clock, reset, !req_accept, $stable(frame_cnt_ff) && $stable(drop_cnt_ff), "counter changed without a request")

endmodule

/* test/tb_multi_mode_byte_frame_assembler_unit.sv */
module tb_multi_mode_byte_frame_assembler_unit;
   import mmbfa_pkg::*;

   localparam int FRAME_MAX = 64;
   localparam int DELIM_MAX = 4;

   // Clock and reset. Reset is synchronous and held high at the start of the run.
   logic clock = 1'b0;
   logic reset;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Block ports.
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   multi_mode_byte_frame_assembler_unit #(
      .FRAME_MAX(FRAME_MAX),
      .DELIM_MAX(DELIM_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copy as last written, and the framing state that follows the block.
   cfg_type     active_cfg = CFG_RESET;
   logic [7:0]  held_bytes [FRAME_MAX];
   int          held_count = 0;
   bit          in_discard = 1'b0;
   bit          in_sentinel_frame = 1'b0;
   int          quiet_count = 0;
   bit          bytes_seen = 1'b0;
   logic [31:0] frame_count = '0;
   logic [31:0] drop_count = '0;

   // Results that the block owes, oldest first.
   rsp_type     frame_results_due [$];
   rsp_type     due_item;

   int          mismatch_count = 0;
   int          requests_sent = 0;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;

   // ------------------------------------------------------------------
   // Framing arithmetic, kept in step with every accepted request.
   // ------------------------------------------------------------------

   // A max_length of zero, or one above the buffer size, means the full buffer.
   function automatic int effective_max();
      int m;
      m = active_cfg.max_length;
      if (m == 0 || m > FRAME_MAX) return FRAME_MAX;
      return m;
   endfunction

   // Delimiter length zero acts as one; large values clamp to the delimiter width.
   function automatic int effective_delim_len();
      int d;
      d = active_cfg.delimiter_length;
      if (d == 0) d = 1;
      if (d > DELIM_MAX) d = DELIM_MAX;
      if (d > FRAME_MAX) d = FRAME_MAX;
      return d;
   endfunction

   function automatic logic [7:0] delim_byte(input int i);
      return active_cfg.delimiter_bytes[8 * (i % 4) +: 8];
   endfunction

   // A byte that arrives with the buffer full is simply lost.
   function automatic void hold_byte(input logic [7:0] b);
      if (held_count < FRAME_MAX) begin
         held_bytes[held_count] = b;
         held_count++;
      end
   endfunction

   function automatic void drop_held_frame();
      drop_count++;
      held_count = 0;
   endfunction

   function automatic bit tail_is_delimiter(input int dlen);
      if (held_count < dlen) return 1'b0;
      for (int i = 0; i < dlen; i++) begin
         if (held_bytes[held_count - dlen + i] != delim_byte(i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Returns the payload length of a frame that this byte completes, or zero.
   function automatic int frame_on_byte(input logic [7:0] b);
      int mx;
      int dlen;
      int fl;
      int n;
      mx = effective_max();
      dlen = effective_delim_len();
      n = 0;
      case (active_cfg.frame_mode)
         MODE_DELIM: begin
            if (in_discard) begin
               // While discarding, only the last dlen - 1 bytes are kept, so the
               // buffer acts as a window that slides over the incoming stream.
               if (held_count >= dlen) begin
                  for (int i = 0; i < dlen - 1; i++) begin
                     held_bytes[i] = held_bytes[held_count - (dlen - 1) + i];
                  end
                  held_count = dlen - 1;
               end
               hold_byte(b);
               if (tail_is_delimiter(dlen)) begin
                  in_discard = 1'b0;
                  held_count = 0;
               end
            end else begin
               hold_byte(b);
               if (tail_is_delimiter(dlen)) begin
                  // An empty frame is skipped but still closes the frame.
                  n = held_count - dlen;
                  if (n > 0) frame_count++;
                  held_count = 0;
               end else if (held_count >= mx) begin
                  drop_held_frame();
                  in_discard = 1'b1;
               end
            end
         end
         MODE_FIXED: begin
            fl = active_cfg.fixed_length;
            if (fl == 0) fl = 1;
            if (fl > mx) fl = mx;
            hold_byte(b);
            if (held_count >= fl) begin
               n = held_count;
               frame_count++;
               held_count = 0;
            end
         end
         MODE_SENTINEL: begin
            if (!in_sentinel_frame) begin
               if (b == active_cfg.start_byte) begin
                  in_sentinel_frame = 1'b1;
                  held_count = 0;
               end
            end else if (b == active_cfg.end_byte) begin
               // The end test comes first, so equal sentinels close the frame.
               n = held_count;
               if (n > 0) frame_count++;
               in_sentinel_frame = 1'b0;
               held_count = 0;
            end else if (b == active_cfg.start_byte) begin
               // A repeated start drops what was gathered and starts over.
               drop_held_frame();
            end else begin
               hold_byte(b);
               if (held_count >= mx) begin
                  drop_held_frame();
                  in_sentinel_frame = 1'b0;
               end
            end
         end
         default: begin
            hold_byte(b);
            if (held_count >= mx) drop_held_frame();
         end
      endcase
      return n;
   endfunction

   // The quiet count runs in every mode once a byte has been seen, but only
   // idle mode closes a frame on it.
   function automatic int frame_on_tick();
      int n;
      if (!bytes_seen) return 0;
      if (quiet_count < 16'hFFFF) quiet_count++;
      if (active_cfg.frame_mode != MODE_IDLE || held_count == 0) return 0;
      if (quiet_count < active_cfg.idle_timeout) return 0;
      n = held_count;
      frame_count++;
      held_count = 0;
      return n;
   endfunction

   // Updates the framing state for one accepted request and queues what the
   // block has to return for it: the payload bytes of a completed frame, or a
   // single status result.
   function automatic void advance_framer(input req_type r);
      int n;
      rsp_type item;
      n = 0;
      case (r.kind)
         KIND_DATA: begin
            n = frame_on_byte(r.data_byte);
            quiet_count = 0;
            bytes_seen = 1'b1;
         end
         KIND_TICK: n = frame_on_tick();
         KIND_RESYNC: begin
            held_count = 0;
            in_discard = 1'b0;
            in_sentinel_frame = 1'b0;
            bytes_seen = 1'b0;
            quiet_count = 0;
         end
         default: ;
      endcase
      item.frames_total = frame_count;
      item.drops_total = drop_count;
      if (n == 0) begin
         item.has_byte = 1'b0;
         item.frame_byte = 8'h00;
         item.last_of_frame = 1'b1;
         frame_results_due.push_back(item);
      end else begin
         for (int i = 0; i < n; i++) begin
            item.has_byte = 1'b1;
            item.frame_byte = held_bytes[i];
            item.last_of_frame = (i == n - 1);
            frame_results_due.push_back(item);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Driving the block.
   // ------------------------------------------------------------------

   // Sends one request. Valid may idle low before it, but once raised it stays
   // high until the request is taken. Valid is left high on return, so that a
   // request sent right after keeps it high without a drop in between.
   task automatic send_request(input logic [1:0] kind, input logic [7:0] value);
      req_type r;
      r.kind = kind;
      r.data_byte = value;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      advance_framer(r);
   endtask

   // Lowers valid and waits until every owed result has come back and the block has surely settled.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register and keeps csr_valid high, so that back to back writes
   // do not drop it in between; apply_config lowers it at the end.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FRAME_MODE:       active_cfg.frame_mode = value[1:0];
         CSR_DELIMITER_BYTES:  active_cfg.delimiter_bytes = value;
         CSR_DELIMITER_LENGTH: active_cfg.delimiter_length = value[2:0];
         CSR_FIXED_LENGTH:     active_cfg.fixed_length = value[6:0];
         CSR_START_BYTE:       active_cfg.start_byte = value[7:0];
         CSR_END_BYTE:         active_cfg.end_byte = value[7:0];
         CSR_IDLE_TIMEOUT:     active_cfg.idle_timeout = value[15:0];
         CSR_MAX_LENGTH:       active_cfg.max_length = value[6:0];
         default: ;
      endcase
   endtask

   // Registers change only while no request is in flight. Framing state that
   // is partly built survives the change, which is part of what gets tested.
   task automatic apply_config(input cfg_type c);
      wait_for_idle();
      write_register(CSR_FRAME_MODE, 32'(c.frame_mode));
      write_register(CSR_DELIMITER_BYTES, c.delimiter_bytes);
      write_register(CSR_DELIMITER_LENGTH, 32'(c.delimiter_length));
      write_register(CSR_FIXED_LENGTH, 32'(c.fixed_length));
      write_register(CSR_START_BYTE, 32'(c.start_byte));
      write_register(CSR_END_BYTE, 32'(c.end_byte));
      write_register(CSR_IDLE_TIMEOUT, 32'(c.idle_timeout));
      write_register(CSR_MAX_LENGTH, 32'(c.max_length));
      csr_valid <= 1'b0;
   endtask

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // ------------------------------------------------------------------
   // Checking. Every result taken is held against the oldest one owed.
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_results_due.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with none owed", rsp_data));
         end else begin
            due_item = frame_results_due.pop_front();
            if (rsp_data.has_byte !== due_item.has_byte)
               report_mismatch($sformatf("has_byte got %b, expected %b",
                                         rsp_data.has_byte, due_item.has_byte));
            if (rsp_data.frame_byte !== due_item.frame_byte)
               report_mismatch($sformatf("frame_byte got %h, expected %h",
                                         rsp_data.frame_byte, due_item.frame_byte));
            if (rsp_data.last_of_frame !== due_item.last_of_frame)
               report_mismatch($sformatf("last_of_frame got %b, expected %b",
                                         rsp_data.last_of_frame, due_item.last_of_frame));
            if (rsp_data.frames_total !== due_item.frames_total)
               report_mismatch($sformatf("frames_total got %0d, expected %0d",
                                         rsp_data.frames_total, due_item.frames_total));
            if (rsp_data.drops_total !== due_item.drops_total)
               report_mismatch($sformatf("drops_total got %0d, expected %0d",
                                         rsp_data.drops_total, due_item.drops_total));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Delimiter mode from the reset settings: an empty frame is skipped, then a
   // frame with both byte extremes. Then a two byte delimiter with a tiny
   // limit, so that the frame overflows and the window discards until the
   // delimiter shows up.
   task automatic test_delimiter_mode();
      cfg_type next_cfg;
      send_request(KIND_DATA, 8'h0A);
      send_request(KIND_DATA, 8'hFF);
      send_request(KIND_DATA, 8'h00);
      send_request(KIND_DATA, 8'h0A);
      next_cfg = active_cfg;
      next_cfg.delimiter_bytes = 32'h0000_0A0D;
      next_cfg.delimiter_length = 3'd2;
      next_cfg.max_length = 7'd2;
      apply_config(next_cfg);
      send_request(KIND_DATA, 8'h41);
      send_request(KIND_DATA, 8'h42);
      send_request(KIND_DATA, 8'h0D);
      send_request(KIND_DATA, 8'h0A);
   endtask

   // Fixed mode closes a frame exactly at the set length.
   task automatic test_fixed_mode();
      cfg_type next_cfg;
      next_cfg = active_cfg;
      next_cfg.frame_mode = MODE_FIXED;
      next_cfg.fixed_length = 7'd3;
      next_cfg.max_length = 7'd0;
      apply_config(next_cfg);
      send_request(KIND_DATA, 8'h11);
      send_request(KIND_DATA, 8'h22);
      send_request(KIND_DATA, 8'h33);
   endtask

   // Sentinel mode: a byte outside a frame is ignored, a repeated start drops
   // the frame and starts a new one. With equal sentinels the second one
   // closes an empty frame.
   task automatic test_sentinel_mode();
      cfg_type next_cfg;
      next_cfg = active_cfg;
      next_cfg.frame_mode = MODE_SENTINEL;
      next_cfg.start_byte = 8'h02;
      next_cfg.end_byte = 8'h03;
      apply_config(next_cfg);
      send_request(KIND_DATA, 8'h55);
      send_request(KIND_DATA, 8'h02);
      send_request(KIND_DATA, 8'h66);
      send_request(KIND_DATA, 8'h02);
      send_request(KIND_DATA, 8'h77);
      send_request(KIND_DATA, 8'h03);
      next_cfg = active_cfg;
      next_cfg.start_byte = 8'h7E;
      next_cfg.end_byte = 8'h7E;
      apply_config(next_cfg);
      send_request(KIND_DATA, 8'h7E);
      send_request(KIND_DATA, 8'h7E);
   endtask

   // Idle mode with a zero timeout: a tick before any byte counts nothing, and
   // the first tick after a byte closes the frame.
   task automatic test_idle_mode();
      cfg_type next_cfg;
      next_cfg = active_cfg;
      next_cfg.frame_mode = MODE_IDLE;
      next_cfg.idle_timeout = 16'd0;
      apply_config(next_cfg);
      send_request(KIND_RESYNC, 8'h00);
      send_request(KIND_TICK, 8'hFF);
      send_request(KIND_DATA, 8'h99);
      send_request(KIND_TICK, 8'h00);
   endtask

   // A resync request throws away a partial frame and the quiet history, and a
   // request of the unused kind changes nothing.
   task automatic test_resync_and_unknown();
      send_request(KIND_DATA, 8'h01);
      send_request(KIND_RESYNC, 8'hFF);
      send_request(KIND_TICK, 8'h00);
      send_request(2'd3, 8'hA5);
   endtask

   // Random settings, each followed by a few well formed sequences for the
   // chosen mode with random content, mixed with noise requests. Bursts run
   // until the requested number of requests has gone out.
   task automatic test_random_traffic(input int item_goal);
      cfg_type c;
      int first;
      int mx;
      int dlen;
      int len;
      int ticks;
      int cap;
      first = requests_sent;
      while (requests_sent - first < item_goal) begin
         c.frame_mode = $urandom_range(3);
         c.delimiter_bytes = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
         c.delimiter_length = $urandom_range(7);
         case ($urandom_range(7))
            0: c.fixed_length = 7'd0;
            1: c.fixed_length = 7'd127;
            2: c.fixed_length = 7'd64;
            default: c.fixed_length = $urandom_range(1, 10);
         endcase
         c.start_byte = $urandom_range(255);
         c.end_byte = ($urandom_range(9) == 0) ? c.start_byte : 8'($urandom_range(255));
         c.idle_timeout = ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom_range(6));
         case ($urandom_range(7))
            0: c.max_length = 7'd0;
            1: c.max_length = 7'd127;
            2: c.max_length = 7'd64;
            3: c.max_length = 7'd1;
            default: c.max_length = $urandom_range(2, 16);
         endcase
         apply_config(c);
         mx = effective_max();
         dlen = effective_delim_len();
         cap = (mx > 8) ? 8 : mx;
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(9) == 0) begin
               send_request($urandom_range(3), $urandom);
            end else begin
               case (active_cfg.frame_mode)
                  MODE_DELIM: begin
                     // Now and then the payload runs past the limit on purpose.
                     if ($urandom_range(7) == 0) len = $urandom_range(mx, mx + 3);
                     else len = $urandom_range(0, cap - 1);
                     repeat (len) send_request(KIND_DATA, $urandom);
                     for (int i = 0; i < dlen; i++) send_request(KIND_DATA, delim_byte(i));
                  end
                  MODE_FIXED: begin
                     len = active_cfg.fixed_length;
                     if (len == 0) len = 1;
                     if (len > mx) len = mx;
                     repeat (len + $urandom_range(1)) send_request(KIND_DATA, $urandom);
                  end
                  MODE_SENTINEL: begin
                     send_request(KIND_DATA, active_cfg.start_byte);
                     len = ($urandom_range(7) == 0) ? mx : $urandom_range(0, cap);
                     for (int i = 0; i < len; i++) begin
                        if (i == len / 2 && $urandom_range(5) == 0)
                           send_request(KIND_DATA, active_cfg.start_byte);
                        send_request(KIND_DATA, $urandom);
                     end
                     send_request(KIND_DATA, active_cfg.end_byte);
                  end
                  default: begin
                     len = ($urandom_range(7) == 0) ? mx : $urandom_range(1, cap);
                     repeat (len) send_request(KIND_DATA, $urandom);
                     // Enough ticks to reach a small timeout; a huge one just
                     // leaves the frame open for a later burst.
                     if (active_cfg.idle_timeout > 8) ticks = $urandom_range(1, 3);
                     else ticks = active_cfg.idle_timeout + $urandom_range(1, 2);
                     repeat (ticks) send_request(KIND_TICK, $urandom);
                  end
               endcase
            end
         end
      end
   endtask

   // The quiet count must stop at its top value rather than wrap. A byte is
   // held in delimiter mode while the count runs past the top, then idle
   // mode with the largest timeout must close the frame on the next tick.
   task automatic test_quiet_saturation();
      cfg_type next_cfg;
      next_cfg = active_cfg;
      next_cfg.frame_mode = MODE_DELIM;
      next_cfg.delimiter_bytes = 32'h0000_000A;
      next_cfg.delimiter_length = 3'd1;
      next_cfg.max_length = 7'd0;
      apply_config(next_cfg);
      send_request(KIND_RESYNC, 8'h00);
      send_request(KIND_DATA, 8'h5A);
      repeat (65537) send_request(KIND_TICK, 8'h00);
      next_cfg = active_cfg;
      next_cfg.frame_mode = MODE_IDLE;
      next_cfg.idle_timeout = 16'hFFFF;
      apply_config(next_cfg);
      send_request(KIND_TICK, 8'h00);
      send_request(KIND_TICK, 8'h00);
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run.
   // ------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // First phase: the sender rarely idles and the receiver mostly stalls.
      sender_idle_pct = 19;
      receiver_idle_pct = 86;
      test_delimiter_mode();
      test_fixed_mode();
      test_sentinel_mode();
      test_idle_mode();
      test_resync_and_unknown();
      test_random_traffic(105);

      // Second phase: the other way round.
      sender_idle_pct = 86;
      receiver_idle_pct = 19;
      test_random_traffic(105);

      // Third phase: both sides run flat out.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_traffic(100);
      test_quiet_saturation();

      wait_for_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && frame_results_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
